// ===== rtl/mwcrg_pkg.sv =====
// Package for the multiply-with-carry random generator.
// Holds the recurrence constants, control word types and the microcode ROM.
// No dependencies.
package mwcrg_pkg;

   localparam int unsigned WordWidth    = 32;
   localparam int unsigned PcWidth      = 5;
   localparam int unsigned CsrAddrWidth = 3;

   localparam logic [WordWidth-1:0] MWC_A3      = 32'd2111111111;
   localparam logic [WordWidth-1:0] MWC_A2      = 32'd1492;
   localparam logic [WordWidth-1:0] MWC_A1      = 32'd1776;
   localparam logic [WordWidth-1:0] MWC_A0      = 32'd5115;
   localparam logic [WordWidth-1:0] SEED_MULT   = 32'd29943829;
   localparam logic [WordWidth-1:0] ERROR_VALUE = 32'h8000_0000;

   localparam logic [2:0] SEED_LAST   = 3'd4;   // fifth seed value goes to carry
   localparam logic [4:0] WARMUP_LAST = 5'd19;  // twenty warm-up draws

   // register index decode (paddr[2] selects the word)
   localparam logic CSR_SEED_IDX = 1'b0;

   // program addresses
   localparam logic [PcWidth-1:0] PC_RESET     = 5'd0;
   localparam logic [PcWidth-1:0] PC_SEED_MUL  = 5'd1;
   localparam logic [PcWidth-1:0] PC_WARM      = 5'd3;
   localparam logic [PcWidth-1:0] PC_IDLE      = 5'd8;
   localparam logic [PcWidth-1:0] PC_UNI       = 5'd9;
   localparam logic [PcWidth-1:0] PC_INT       = 5'd15;
   localparam logic [PcWidth-1:0] PC_ERR       = 5'd22;

   typedef enum logic [2:0] {
      MUL_NONE, MUL_X3, MUL_X2, MUL_X1, MUL_X0, MUL_SEED, MUL_MAP
   } mul_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD, ACC_CARRY, ACC_ADD
   } acc_op_type;

   typedef enum logic [2:0] {
      ACT_NONE, ACT_SEED_LOAD, ACT_SEED_STORE, ACT_COMMIT,
      ACT_RES_UNI, ACT_RES_INT, ACT_RES_ERR
   } act_type;

   typedef enum logic [2:0] {
      JMP_NEXT, JMP_GOTO, JMP_SEED_LOOP, JMP_WARM_LOOP, JMP_DISPATCH
   } jmp_type;

   typedef struct packed {
      mul_sel_type        mul_sel;
      acc_op_type         acc_op;
      act_type            act;
      jmp_type            jmp;
      logic [PcWidth-1:0] target;
   } ucode_type;

   // One draw: four products through the shared multiplier, the adder one
   // step behind, commit on the fifth step.
   function automatic ucode_type ucode_rom(input logic [PcWidth-1:0] addr);
      ucode_type uc;
      case (addr)
         5'd0:  uc = '{MUL_NONE, ACC_HOLD,  ACT_SEED_LOAD,  JMP_NEXT,      PC_RESET};
         5'd1:  uc = '{MUL_SEED, ACC_HOLD,  ACT_NONE,       JMP_NEXT,      PC_RESET};
         5'd2:  uc = '{MUL_NONE, ACC_HOLD,  ACT_SEED_STORE, JMP_SEED_LOOP, PC_SEED_MUL};
         // warm-up draw loop
         5'd3:  uc = '{MUL_X3,   ACC_CARRY, ACT_NONE,       JMP_NEXT,      PC_RESET};
         5'd4:  uc = '{MUL_X2,   ACC_ADD,   ACT_NONE,       JMP_NEXT,      PC_RESET};
         5'd5:  uc = '{MUL_X1,   ACC_ADD,   ACT_NONE,       JMP_NEXT,      PC_RESET};
         5'd6:  uc = '{MUL_X0,   ACC_ADD,   ACT_NONE,       JMP_NEXT,      PC_RESET};
         5'd7:  uc = '{MUL_NONE, ACC_HOLD,  ACT_COMMIT,     JMP_WARM_LOOP, PC_WARM};
         // wait for a request
         5'd8:  uc = '{MUL_NONE, ACC_HOLD,  ACT_NONE,       JMP_DISPATCH,  PC_IDLE};
         // uniform draw
         5'd9:  uc = '{MUL_X3,   ACC_CARRY, ACT_NONE,       JMP_NEXT,      PC_RESET};
         5'd10: uc = '{MUL_X2,   ACC_ADD,   ACT_NONE,       JMP_NEXT,      PC_RESET};
         5'd11: uc = '{MUL_X1,   ACC_ADD,   ACT_NONE,       JMP_NEXT,      PC_RESET};
         5'd12: uc = '{MUL_X0,   ACC_ADD,   ACT_NONE,       JMP_NEXT,      PC_RESET};
         5'd13: uc = '{MUL_NONE, ACC_HOLD,  ACT_COMMIT,     JMP_NEXT,      PC_RESET};
         5'd14: uc = '{MUL_NONE, ACC_HOLD,  ACT_RES_UNI,    JMP_GOTO,      PC_IDLE};
         // integer draw
         5'd15: uc = '{MUL_X3,   ACC_CARRY, ACT_NONE,       JMP_NEXT,      PC_RESET};
         5'd16: uc = '{MUL_X2,   ACC_ADD,   ACT_NONE,       JMP_NEXT,      PC_RESET};
         5'd17: uc = '{MUL_X1,   ACC_ADD,   ACT_NONE,       JMP_NEXT,      PC_RESET};
         5'd18: uc = '{MUL_X0,   ACC_ADD,   ACT_NONE,       JMP_NEXT,      PC_RESET};
         5'd19: uc = '{MUL_NONE, ACC_HOLD,  ACT_COMMIT,     JMP_NEXT,      PC_RESET};
         5'd20: uc = '{MUL_MAP,  ACC_HOLD,  ACT_NONE,       JMP_NEXT,      PC_RESET};
         5'd21: uc = '{MUL_NONE, ACC_HOLD,  ACT_RES_INT,    JMP_GOTO,      PC_IDLE};
         // bad range: no draw
         5'd22: uc = '{MUL_NONE, ACC_HOLD,  ACT_RES_ERR,    JMP_GOTO,      PC_IDLE};
         default: uc = '{MUL_NONE, ACC_HOLD, ACT_NONE,      JMP_GOTO,      PC_RESET};
      endcase
      return uc;
   endfunction

endpackage

// ===== rtl/multiply_with_carry_random_generator_top.sv =====
// One request at a time: a uniform draw, an integer draw (a draw plus a range map),
// or, for a bad range, an error word with no draw; req_tready is low until it is
// done. The single shared 32x32 multiplier takes four products per draw.
// Reset is synchronous; reset or a seed write runs seeding plus 20 warm-up draws,
// with req_tready low. A finished word waits in the output register.
// Depends on mwcrg_pkg (constants, control word types, microcode ROM).
module multiply_with_carry_random_generator_top
   import mwcrg_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   // request channel
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [63:0]             req_tdata,   // [31:0] range_low, [63:32] range_high
   input  logic                    req_tuser,   // [0] kind
   // result channel
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [63:0]             rsp_tdata,   // [31:0] uniform_word, [63:32] integer_value
   output logic                    rsp_tuser,   // [0] range_error
   // configuration port
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CsrAddrWidth-1:0] csr_paddr,
   input  logic [31:0]             csr_pwdata,
   output logic [31:0]             csr_prdata,
   output logic                    csr_pready
);

   ucode_type cw;

   logic [PcWidth-1:0]   pc_ff, pc_in;
   logic [WordWidth-1:0] seed_ff, seed_in;
   logic [2:0]           seed_idx_ff, seed_idx_in;
   logic [4:0]           warm_ff, warm_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic [WordWidth-1:0] hist_ff [4];
   logic [WordWidth-1:0] hist_in [4];
   logic [WordWidth-1:0] carry_ff, carry_in;
   logic [WordWidth-1:0] s_ff, s_in;
   logic [63:0]          acc_ff, acc_in;
   logic [63:0]          prod_ff, prod_in;
   logic [WordWidth-1:0] low_ff, low_in;
   logic [WordWidth-1:0] interval_ff, interval_in;
   logic [WordWidth-1:0] rsp_word_ff, rsp_word_in;
   logic [WordWidth-1:0] rsp_int_ff, rsp_int_in;
   logic                 rsp_err_ff, rsp_err_in;

   logic                 cfg_wr;
   logic                 req_accept;
   logic                 res_step;
   logic                 stall;
   logic [WordWidth-1:0] mul_a, mul_b;
   logic [63:0]          sum;
   logic [WordWidth-1:0] s_store;
   logic [WordWidth-1:0] req_low, req_high, req_interval;
   logic                 req_bad;

   assign cw = ucode_rom(pc_ff);

   assign cfg_wr = csr_psel && csr_penable && csr_pwrite && (csr_paddr[2] == CSR_SEED_IDX);
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == CSR_SEED_IDX) ? seed_ff : '0;

   assign req_tready = (pc_ff == PC_IDLE) && !cfg_wr;
   assign req_accept = req_tvalid && req_tready;

   assign req_low      = req_tdata[31:0];
   assign req_high     = req_tdata[63:32];
   assign req_interval = req_high - req_low + 32'd1;
   assign req_bad      = (req_interval == '0) || req_interval[31];

   assign res_step = (cw.act == ACT_RES_UNI) || (cw.act == ACT_RES_INT)
                  || (cw.act == ACT_RES_ERR);
   // hold the whole datapath when a result step finds the output word still waiting
   assign stall = res_step && rsp_valid_ff && !rsp_tready;

   assign sum     = acc_ff + prod_ff;
   assign s_store = prod_ff[31:0] - 32'd1;

   always_comb begin
      unique case (cw.mul_sel)
         MUL_X3:   begin mul_a = MWC_A3;      mul_b = hist_ff[3]; end
         MUL_X2:   begin mul_a = MWC_A2;      mul_b = hist_ff[2]; end
         MUL_X1:   begin mul_a = MWC_A1;      mul_b = hist_ff[1]; end
         MUL_X0:   begin mul_a = MWC_A0;      mul_b = hist_ff[0]; end
         MUL_SEED: begin mul_a = SEED_MULT;   mul_b = s_ff;       end
         MUL_MAP:  begin mul_a = interval_ff; mul_b = hist_ff[0]; end
         default:  begin mul_a = '0;          mul_b = '0;         end
      endcase
   end

   // sequencer
   always_comb begin
      pc_in = pc_ff;
      if (!stall) begin
         unique case (cw.jmp)
            JMP_NEXT:      pc_in = pc_ff + 5'd1;
            JMP_GOTO:      pc_in = cw.target;
            JMP_SEED_LOOP: pc_in = (seed_idx_ff != SEED_LAST) ? cw.target : pc_ff + 5'd1;
            JMP_WARM_LOOP: pc_in = (warm_ff != WARMUP_LAST) ? cw.target : pc_ff + 5'd1;
            JMP_DISPATCH: begin
               if (req_accept) begin
                  if (!req_tuser)   pc_in = PC_UNI;
                  else if (req_bad) pc_in = PC_ERR;
                  else              pc_in = PC_INT;
               end
            end
            default:       pc_in = PC_RESET;
         endcase
      end
      if (cfg_wr) begin
         pc_in = PC_RESET;
      end
   end

   // datapath
   always_comb begin
      seed_in      = cfg_wr ? csr_pwdata : seed_ff;
      seed_idx_in  = seed_idx_ff;
      warm_in      = warm_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      hist_in      = hist_ff;
      carry_in     = carry_ff;
      s_in         = s_ff;
      acc_in       = acc_ff;
      prod_in      = prod_ff;
      low_in       = low_ff;
      interval_in  = interval_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_int_in   = rsp_int_ff;
      rsp_err_in   = rsp_err_ff;

      if (req_accept) begin
         low_in      = req_low;
         interval_in = req_interval;
      end

      if (!stall) begin
         prod_in = mul_a * mul_b;

         case (cw.acc_op)
            ACC_CARRY: acc_in = {32'd0, carry_ff};
            ACC_ADD:   acc_in = sum;
            default:   acc_in = acc_ff;
         endcase

         case (cw.act)
            ACT_SEED_LOAD: begin
               s_in        = seed_ff;
               seed_idx_in = '0;
               warm_in     = '0;
            end
            ACT_SEED_STORE: begin
               s_in        = s_store;
               seed_idx_in = seed_idx_ff + 3'd1;
               if (seed_idx_ff == SEED_LAST) carry_in = s_store;
               else hist_in[seed_idx_ff[1:0]] = s_store;
            end
            ACT_COMMIT: begin
               hist_in[3] = hist_ff[2];
               hist_in[2] = hist_ff[1];
               hist_in[1] = hist_ff[0];
               hist_in[0] = sum[31:0];
               carry_in   = sum[63:32];
               if (cw.jmp == JMP_WARM_LOOP) warm_in = warm_ff + 5'd1;
            end
            ACT_RES_UNI: begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = hist_ff[0];
               rsp_int_in   = '0;
               rsp_err_in   = 1'b0;
            end
            ACT_RES_INT: begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = hist_ff[0];
               rsp_int_in   = low_ff + prod_ff[63:32];
               rsp_err_in   = 1'b0;
            end
            ACT_RES_ERR: begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = '0;
               rsp_int_in   = ERROR_VALUE;
               rsp_err_in   = 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= PC_RESET;
         seed_ff      <= '0;
         seed_idx_ff  <= '0;
         warm_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         seed_ff      <= seed_in;
         seed_idx_ff  <= seed_idx_in;
         warm_ff      <= warm_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hist_ff     <= hist_in;
      carry_ff    <= carry_in;
      s_ff        <= s_in;
      acc_ff      <= acc_in;
      prod_ff     <= prod_in;
      low_ff      <= low_in;
      interval_ff <= interval_in;
      rsp_word_ff <= rsp_word_in;
      rsp_int_ff  <= rsp_int_in;
      rsp_err_ff  <= rsp_err_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_int_ff, rsp_word_ff};
   assign rsp_tuser  = rsp_err_ff;

endmodule

// ===== rtl/mwcrg_checker.sv =====
// Port-level checks for the multiply-with-carry random generator.
// Depends on mwcrg_pkg; bound to multiply_with_carry_random_generator_top.
module mwcrg_checker
   import mwcrg_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_tvalid,
   input logic                    req_tready,
   input logic                    rsp_tvalid,
   input logic                    rsp_tready,
   input logic [63:0]             rsp_tdata,
   input logic                    rsp_tuser,
   input logic                    csr_psel,
   input logic                    csr_penable,
   input logic                    csr_pwrite,
   input logic [CsrAddrWidth-1:0] csr_paddr
);

   // stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result word changed while stalled");

   // error word has a fixed payload
   a_err_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == {ERROR_VALUE, 32'd0})
      else $error("range error word carries wrong payload");

   // seeding follows reset
   a_reset_busy: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("request taken right after reset");

   // seeding follows a seed write
   a_seed_busy: assert property (@(posedge clock)
      csr_psel && csr_penable && csr_pwrite && (csr_paddr[2] == CSR_SEED_IDX) |=> !req_tready)
      else $error("request taken right after seed write");

   // one request at a time in the sequencer
   a_one_at_a_time: assert property (@(posedge clock)
      req_tvalid && req_tready |=> !req_tready)
      else $error("back-to-back request accepted");

endmodule

bind multiply_with_carry_random_generator_top mwcrg_checker u_mwcrg_checker (.*);
